@@ rtl/core/button_memory_injector_fsm_macros.svh @@
// assertion macros shared by the button memory injector rtl
`ifndef BUTTON_MEMORY_INJECTOR_FSM_MACROS_SVH
`define BUTTON_MEMORY_INJECTOR_FSM_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define BMI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is active
`define BMI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/bmi_pkg.sv @@
// types and constants of the button memory injector
package bmi_pkg;

	localparam int CFG_W = 16;

	localparam logic [CFG_W-1:0] IGN_DELAY_RST = 16'd1000;
	localparam logic [CFG_W-1:0] GRACE_RST     = 16'd250;
	localparam logic [CFG_W-1:0] INJECT_RST    = 16'd500;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_IGN_DELAY = 2'd0,
		CFG_GRACE     = 2'd1,
		CFG_INJECT    = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_idx_t;

	// operating mode codes
	typedef enum logic [2:0] {
		MODE_WAIT       = 3'd0,
		MODE_POLL       = 3'd1,
		MODE_INJ_SPORT  = 3'd2,
		MODE_INJ_PSE    = 3'd3,
		MODE_INJ_AUTO   = 3'd4
	} mode_t;

	// channel order: sport, pse, autostart
	localparam int NCH = 3;

	typedef struct packed {
		logic [CFG_W-1:0] ign_delay;
		logic [CFG_W-1:0] grace;
		logic [CFG_W-1:0] inject;
	} cfg_regs_t;

	typedef struct packed {
		logic ignition_on;
		logic memory_enabled;
		logic sport_plus_lamp;
		logic [NCH-1:0] led;
		logic [NCH-1:0] sw;
	} tick_t;

	typedef struct packed {
		logic [NCH-1:0] sw_prev;
		logic [NCH-1:0] saved;
		logic [NCH-1:0] inject;
	} flags_t;

	// inject mode that belongs to a channel
	function automatic mode_t inj_mode(input logic [1:0] ch);
		mode_t m;
		case (ch)
			2'd0:    m = MODE_INJ_SPORT;
			2'd1:    m = MODE_INJ_PSE;
			default: m = MODE_INJ_AUTO;
		endcase
		return m;
	endfunction

endpackage

@@ rtl/core/bmi_cfg.sv @@
// configuration register file of the button memory injector
module bmi_cfg
	import bmi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [CFG_W-1:0] wr_data,
	output cfg_regs_t        regs
);

	cfg_regs_t regs_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.ign_delay <= IGN_DELAY_RST;
			regs_q.grace     <= GRACE_RST;
			regs_q.inject    <= INJECT_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_IGN_DELAY: regs_q.ign_delay <= wr_data;
				CFG_GRACE:     regs_q.grace     <= wr_data;
				CFG_INJECT:    regs_q.inject    <= wr_data;
				default:       regs_q           <= regs_q;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

@@ rtl/core/bmi_step.sv @@
// next-state logic for one millisecond tick
module bmi_step
	import bmi_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  tick_t                             tick,
	input  cfg_regs_t                         cfg,
	input  mode_t                             mode_cur,
	input  logic [COUNT_WIDTH-1:0]            mode_time_cur,
	input  logic [COUNT_WIDTH-1:0]            ign_time_cur,
	input  logic [NCH-1:0][COUNT_WIDTH-1:0]   since_cur,
	input  flags_t                            flags_cur,
	output mode_t                             mode_nxt,
	output logic [COUNT_WIDTH-1:0]            mode_time_nxt,
	output logic [COUNT_WIDTH-1:0]            ign_time_nxt,
	output logic [NCH-1:0][COUNT_WIDTH-1:0]   since_nxt,
	output flags_t                            flags_nxt,
	output logic                              changed
);

	localparam int CMPW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	// saturating increment
	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// counters that run every tick
	always_comb begin
		ign_time_nxt = tick.ignition_on ? sat_inc(ign_time_cur) : '0;
		for (int i = 0; i < NCH; i++) begin
			since_nxt[i] = (tick.sw[i] != flags_cur.sw_prev[i]) ? '0 : sat_inc(since_cur[i]);
		end
	end

	// mode machine
	always_comb begin
		logic found;
		logic down;
		mode_t mode_eff;
		flags_nxt         = flags_cur;
		flags_nxt.sw_prev = tick.sw;
		changed           = 1'b0;
		found             = 1'b0;
		down              = 1'b0;
		mode_time_nxt     = sat_inc(mode_time_cur);
		mode_eff          = mode_cur;
		if (!tick.ignition_on) begin
			mode_eff      = MODE_WAIT;
			mode_time_nxt = '0;
		end
		mode_nxt = mode_eff;
		case (mode_eff)
			MODE_WAIT: begin
				flags_nxt.inject = '0;
				if (tick.memory_enabled && tick.ignition_on &&
				    CMPW'(ign_time_cur) >= CMPW'(cfg.ign_delay)) begin
					mode_nxt      = MODE_POLL;
					mode_time_nxt = '0;
				end
			end
			MODE_POLL: begin
				// first mismatching channel that is not being pressed wins
				for (int i = 0; i < NCH; i++) begin
					down = tick.sw[i] || (CMPW'(since_nxt[i]) < CMPW'(cfg.grace));
					if (!found && tick.led[i] != flags_cur.saved[i]) begin
						if (down) begin
							flags_nxt.saved[i] = tick.led[i];
							changed            = 1'b1;
						end else if (i != 0 || !tick.sport_plus_lamp) begin
							flags_nxt.inject[i] = 1'b1;
							mode_nxt            = inj_mode(2'(i));
							mode_time_nxt       = '0;
							found               = 1'b1;
						end
					end
				end
			end
			MODE_INJ_SPORT, MODE_INJ_PSE, MODE_INJ_AUTO: begin
				// release the press once the hold time is exceeded
				if (CMPW'(mode_time_nxt) > CMPW'(cfg.inject)) begin
					if (mode_eff == MODE_INJ_SPORT) flags_nxt.inject[0] = 1'b0;
					if (mode_eff == MODE_INJ_PSE)   flags_nxt.inject[1] = 1'b0;
					if (mode_eff == MODE_INJ_AUTO)  flags_nxt.inject[2] = 1'b0;
					mode_nxt      = MODE_POLL;
					mode_time_nxt = '0;
				end
			end
			default: begin
				mode_nxt      = MODE_WAIT;
				mode_time_nxt = '0;
			end
		endcase
	end

endmodule

@@ rtl/core/button_memory_injector_fsm.sv @@
// top level of the button memory injector
//
// Each input transaction is one millisecond tick with the ignition, enable,
// indicator and switch levels. Every tick gives exactly one result
// transaction: the mode, the three press injection drives, the three
// remembered settings and a flag that a remembered bit was rewritten.
// Configuration writes (index 0 ignition delay, 1 press grace, 2 inject
// time) go through a separate valid/ready channel that is always ready;
// the user must make them only while no tick is in flight, as the block
// does not enforce this. An accepted tick sits in the input register,
// and the update logic loads its result into the result register once
// that register is free, from where the receiver takes it.
// Throughput is one tick per cycle while the receiver keeps up; the input
// register and the result register form a two-deep pipeline, so a tick is
// taken while a finished result still waits. When the receiver stalls,
// the result holds and the input register fills, after which in_ready drops.
// Reset puts the block in the wait mode with counters cleared, switch age
// counters saturated, remembered bits and injections off, and the
// configuration registers at 1000, 250 and 500 ms.
module button_memory_injector_fsm
	import bmi_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             ignition_on,
	input  logic             memory_enabled,
	input  logic             sport_lamp,
	input  logic             sport_plus_lamp,
	input  logic             sport_button,
	input  logic             pse_led,
	input  logic             pse_button,
	input  logic             autostart_lamp,
	input  logic             autostart_button,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       mode,
	output logic             sport_inject,
	output logic             pse_inject,
	output logic             autostart_inject,
	output logic             sport_saved,
	output logic             pse_saved,
	output logic             autostart_saved,
	output logic             saved_changed
);

	cfg_regs_t cfg;

	tick_t tick_in;
	tick_t tick_s1;
	logic  valid_s1;
	logic  advance;

	mode_t                           mode_q;
	logic [COUNT_WIDTH-1:0]          mode_time_q;
	logic [COUNT_WIDTH-1:0]          ign_time_q;
	logic [NCH-1:0][COUNT_WIDTH-1:0] since_q;
	flags_t                          flags_q;

	mode_t                           mode_nxt;
	logic [COUNT_WIDTH-1:0]          mode_time_nxt;
	logic [COUNT_WIDTH-1:0]          ign_time_nxt;
	logic [NCH-1:0][COUNT_WIDTH-1:0] since_nxt;
	flags_t                          flags_nxt;
	logic                            changed_nxt;

	logic   out_valid_q;
	mode_t  out_mode_q;
	flags_t out_flags_q;
	logic   out_changed_q;

	logic [NCH-1:0] out_inj;
	logic           out_idle;

	// configuration channel
	assign cfg_ready = 1'b1;

	bmi_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (cfg)
	);

	// pack the input transaction
	always_comb begin
		tick_in.ignition_on     = ignition_on;
		tick_in.memory_enabled  = memory_enabled;
		tick_in.sport_plus_lamp = sport_plus_lamp;
		tick_in.led             = {autostart_lamp, pse_led, sport_lamp};
		tick_in.sw              = {autostart_button, pse_button, sport_button};
	end

	// pipeline control
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1 <= tick_in;
		end
	end

	bmi_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.tick          (tick_s1),
		.cfg           (cfg),
		.mode_cur      (mode_q),
		.mode_time_cur (mode_time_q),
		.ign_time_cur  (ign_time_q),
		.since_cur     (since_q),
		.flags_cur     (flags_q),
		.mode_nxt      (mode_nxt),
		.mode_time_nxt (mode_time_nxt),
		.ign_time_nxt  (ign_time_nxt),
		.since_nxt     (since_nxt),
		.flags_nxt     (flags_nxt),
		.changed       (changed_nxt)
	);

	// block state, updated as a tick moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_WAIT;
			mode_time_q <= '0;
			ign_time_q  <= '0;
			since_q     <= '1;
			flags_q     <= '0;
		end else if (advance) begin
			mode_q      <= mode_nxt;
			mode_time_q <= mode_time_nxt;
			ign_time_q  <= ign_time_nxt;
			since_q     <= since_nxt;
			flags_q     <= flags_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_mode_q    <= mode_nxt;
			out_flags_q   <= flags_nxt;
			out_changed_q <= changed_nxt;
		end
	end

	// result ports
	assign out_valid        = out_valid_q;
	assign mode             = out_mode_q;
	assign sport_inject     = out_flags_q.inject[0];
	assign pse_inject       = out_flags_q.inject[1];
	assign autostart_inject = out_flags_q.inject[2];
	assign sport_saved      = out_flags_q.saved[0];
	assign pse_saved        = out_flags_q.saved[1];
	assign autostart_saved  = out_flags_q.saved[2];
	assign saved_changed    = out_changed_q;

	// checks
	assign out_inj  = out_flags_q.inject;
	assign out_idle = (out_mode_q == MODE_WAIT) || (out_mode_q == MODE_POLL);

`include "button_memory_injector_fsm_macros.svh"

	`BMI_ASSERT_IMPL(a_one_inject, clk, arst_n, out_valid, $onehot0(out_inj), "two injections at once")
	`BMI_ASSERT_IMPL(a_idle_no_inject, clk, arst_n, out_valid && out_idle, out_inj == '0, "idle injection")
	`BMI_ASSERT_IMPL(a_pse_inject, clk, arst_n, out_valid && mode == MODE_INJ_PSE, pse_inject, "no pse drive")
	`BMI_ASSERT_NEXT(a_stage_moves, clk, arst_n, valid_s1 && !out_valid_q, out_valid_q, "tick stuck")

endmodule
